// File: rtl/core/ssg_pkg.sv
// ----------------------------------------------------------------------------
// ssg_pkg
// Shared constants and types for the gap-halving sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package ssg_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    ST_LOAD   = 3'b001,
    ST_SETTLE = 3'b010,
    ST_DRAIN  = 3'b100
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/ssg_ifs.sv
// ----------------------------------------------------------------------------
// ssg_in_if / ssg_out_if
// Valid/ready channels for element beats in and sorted beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssg_in_if #(
  parameter int DATA_WIDTH = ssg_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value;
  logic                         is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface ssg_out_if #(
  parameter int DATA_WIDTH = ssg_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sorted_value;
  logic                         last_out;
  logic                         dropped;

  modport source (output valid, output sorted_value, output last_out, output dropped,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input dropped,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/ssg_cell.sv
// ----------------------------------------------------------------------------
// ssg_cell
// One sorter cell: keeps the smaller of held and incoming, passes the larger
// right; shifts left from its right neighbor while draining.
// ----------------------------------------------------------------------------
`default_nettype none

module ssg_cell #(
  parameter int DATA_WIDTH = ssg_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         shift,
  input  wire logic                         tok_in_vld,
  input  wire logic signed [DATA_WIDTH-1:0] tok_in_data,
  input  wire logic                         right_occ,
  input  wire logic signed [DATA_WIDTH-1:0] right_val,
  output logic                              tok_out_vld,
  output logic signed [DATA_WIDTH-1:0]      tok_out_data,
  output logic                              occ,
  output logic signed [DATA_WIDTH-1:0]      val
);

  logic                         occ_r, occ_nxt;
  logic signed [DATA_WIDTH-1:0] val_r, val_nxt;
  logic                         tv_r, tv_nxt;
  logic signed [DATA_WIDTH-1:0] td_r, td_nxt;

  always_comb begin
    occ_nxt = occ_r;
    val_nxt = val_r;
    tv_nxt  = 1'b0;
    td_nxt  = td_r;
    if (shift) begin
      occ_nxt = right_occ;
      val_nxt = right_val;
    end else if (tok_in_vld) begin
      if (!occ_r) begin
        occ_nxt = 1'b1;
        val_nxt = tok_in_data;
      end else if (tok_in_data < val_r) begin
        val_nxt = tok_in_data;
        tv_nxt  = 1'b1;
        td_nxt  = val_r;
      end else begin
        tv_nxt  = 1'b1;
        td_nxt  = tok_in_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      tv_r  <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      tv_r  <= tv_nxt;
    end
    val_r <= val_nxt;
    td_r  <= td_nxt;
  end

  assign tok_out_vld  = tv_r;
  assign tok_out_data = td_r;
  assign occ          = occ_r;
  assign val          = val_r;

endmodule

`default_nettype wire

// File: rtl/core/shell_sort_gap_halving.sv
// ----------------------------------------------------------------------------
// shell_sort_gap_halving
// Collects signed elements and returns them in ascending order.
//
// in_ch carries one element per beat; a beat with is_last set closes the set.
// Up to DEPTH elements are kept; further beats are accepted and discarded,
// and every result of that set then carries dropped.
// Elements enter a row of DEPTH cells, one beat per cycle while loading;
// each cell keeps the smaller value and hands the larger one to its right neighbor, so the
// row is sorted once the last element has rippled through.
// After the last beat the block waits in a settle state, counting down from
// count while the row settles, then emits one result per cycle from the
// leftmost cell while out_ch.ready is high (the row shifts left on each
// accepted out_ch beat). last_out marks the final result. in_ch.ready is
// low from the last beat until the final result has gone out. A stall on
// out_ch simply holds the row.
// Reset empties all cells and returns to loading.
// ----------------------------------------------------------------------------
`default_nettype none

module shell_sort_gap_halving #(
  parameter int DEPTH      = ssg_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = ssg_pkg::DATA_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ssg_in_if.sink    in_ch,
  ssg_out_if.source out_ch
);

  localparam int CW = $clog2(DEPTH + 1);

  ssg_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   settle_r, settle_nxt;
  logic            ovf_r, ovf_nxt;

  logic accept, full, pop, shift;

  logic                         tv  [0:DEPTH];
  logic signed [DATA_WIDTH-1:0] td  [0:DEPTH];
  logic                         occ [0:DEPTH];
  logic signed [DATA_WIDTH-1:0] val [0:DEPTH];

  assign in_ch.ready = (state_r == ssg_pkg::ST_LOAD);
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CW'(DEPTH));

  assign out_ch.valid        = (state_r == ssg_pkg::ST_DRAIN);
  assign out_ch.sorted_value = val[0];
  assign out_ch.last_out     = (count_r == CW'(1));
  assign out_ch.dropped      = ovf_r;
  assign pop                 = out_ch.valid && out_ch.ready;
  assign shift               = pop;

  assign tv[0]      = accept && !full;
  assign td[0]      = in_ch.value;
  assign occ[DEPTH] = 1'b0;
  assign val[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ssg_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .shift        (shift),
      .tok_in_vld   (tv[i]),
      .tok_in_data  (td[i]),
      .right_occ    (occ[i+1]),
      .right_val    (val[i+1]),
      .tok_out_vld  (tv[i+1]),
      .tok_out_data (td[i+1]),
      .occ          (occ[i]),
      .val          (val[i])
    );
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    settle_nxt = settle_r;
    ovf_nxt    = ovf_r;
    unique case (state_r)
      ssg_pkg::ST_LOAD: begin
        if (accept) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CW'(1);
          end
          if (in_ch.is_last) begin
            settle_nxt = count_nxt;
            state_nxt  = ssg_pkg::ST_SETTLE;
          end
        end
      end
      ssg_pkg::ST_SETTLE: begin
        if (settle_r == '0) begin
          state_nxt = ssg_pkg::ST_DRAIN;
        end else begin
          settle_nxt = settle_r - CW'(1);
        end
      end
      ssg_pkg::ST_DRAIN: begin
        if (pop) begin
          count_nxt = count_r - CW'(1);
          if (count_r == CW'(1)) begin
            ovf_nxt   = 1'b0;
            state_nxt = ssg_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ssg_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ssg_pkg::ST_LOAD;
      count_r  <= '0;
      settle_r <= '0;
      ovf_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      settle_r <= settle_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

// File: dv/tb_shell_sort_gap_halving.sv
// ----------------------------------------------------------------------------
// tb_shell_sort_gap_halving
// Self-checking bench for the gap-halving sorter.
//
// Element sets go in on in_ch and sorted beats come back on out_ch. A local
// model keeps its own copy of the loaded set. At each accepted is_last beat it
// sorts the set and queues the beats it expects. Each out_ch beat is compared
// with the oldest queued beat. Stimulus covers single-element and extreme-value
// sets, duplicates, a full store, sets that overflow the store, a long output
// hold-off, and random sets with bursty input and patterned output stalls.
// ----------------------------------------------------------------------------

module tb_shell_sort_gap_halving;

  localparam int DEPTH      = ssg_pkg::DEPTH_DEF;
  localparam int DW         = ssg_pkg::DATA_WIDTH_DEF;
  localparam int CYCLE_CAP  = 400000;
  localparam int SETTLE_CYC = 2 * DEPTH + 16;
  localparam int RAND_ITEMS = 90;
  localparam int MAX_PRINTS = 20;

  localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};

  typedef struct packed {
    logic signed [DW-1:0] value;
    logic                 last;
    logic                 dropped;
  } sorted_beat_t;

  logic clk;
  logic rst_n;

  ssg_in_if  #(.DATA_WIDTH(DW)) in_ch ();
  ssg_out_if #(.DATA_WIDTH(DW)) out_ch ();

  shell_sort_gap_halving #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DW)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // model state
  logic signed [DW-1:0] set_store [DEPTH];
  int                   set_count;
  logic                 set_overflow;
  sorted_beat_t         expected_beats [$];

  int  error_count;
  int  items_sent;
  int  burst_left;
  bit  gaps_on;
  bit  hold_req;
  int  hold_len;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : cycle_limit
    int cyc;
    for (cyc = 0; cyc < CYCLE_CAP; cyc++) @(posedge clk);
    $display("shell_sort_gap_halving: mismatch");
    $finish;
  end

  task automatic report_mismatch(string what, logic [DW-1:0] got, logic [DW-1:0] exp);
    if (error_count < MAX_PRINTS)
      $display("ERROR %s: got %0h exp %0h", what, got, exp);
    error_count++;
  endtask

  task automatic sort_and_queue();
    int gap;
    int i;
    int pos;
    int k;
    logic signed [DW-1:0] held;
    sorted_beat_t beat;
    gap = set_count;
    while (gap > 1) begin
      gap = gap / 2;
      for (i = 0; i + gap < set_count; i++) begin
        pos  = i;
        held = set_store[i + gap];
        while (pos >= 0 && set_store[pos] > held) begin
          set_store[pos + gap] = set_store[pos];
          pos -= gap;
        end
        set_store[pos + gap] = held;
      end
    end
    for (k = 0; k < set_count; k++) begin
      beat.value   = set_store[k];
      beat.last    = (k == set_count - 1);
      beat.dropped = set_overflow;
      expected_beats.push_back(beat);
    end
    set_count    = 0;
    set_overflow = 1'b0;
  endtask

  task automatic load_element(logic signed [DW-1:0] v, logic last);
    if (set_count < DEPTH) begin
      set_store[set_count] = v;
      set_count++;
    end else begin
      set_overflow = 1'b1;
    end
    if (last) sort_and_queue();
  endtask

  // input prediction and result checking
  always @(posedge clk) begin
    sorted_beat_t exp;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        load_element(in_ch.value, in_ch.is_last);
        items_sent++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected beat", out_ch.sorted_value, '0);
        end else begin
          exp = expected_beats.pop_front();
          if (out_ch.sorted_value !== exp.value)
            report_mismatch("sorted_value", out_ch.sorted_value, exp.value);
          if (out_ch.last_out !== exp.last)
            report_mismatch("last_out", DW'(out_ch.last_out), DW'(exp.last));
          if (out_ch.dropped !== exp.dropped)
            report_mismatch("dropped", DW'(out_ch.dropped), DW'(exp.dropped));
        end
      end
    end
  end

  // receiver: rotating stall pattern, plus on-demand long hold-off
  initial begin : receiver
    logic [7:0] pattern;
    int         phase;
    int         hold_left;
    out_ch.ready = 1'b0;
    pattern      = 8'hff;
    phase        = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = hold_len;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        if (phase % 32 == 0) begin
          case ($urandom_range(0, 3))
            0:       pattern = 8'hff;
            1:       pattern = 8'($urandom) | 8'h01;
            2:       pattern = 8'($urandom & $urandom) | 8'h01;
            default: pattern = 8'hff;
          endcase
        end
        out_ch.ready <= pattern[phase % 8];
        phase++;
      end
    end
  end

  task automatic send_elem(logic signed [DW-1:0] v, logic last);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.value   <= v;
    in_ch.is_last <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic input_idle();
    @(negedge clk);
    in_ch.valid   <= 1'b0;
    in_ch.is_last <= 1'b0;
  endtask

  task automatic wait_drained();
    input_idle();
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [DW-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return DW'($signed($urandom_range(0, 7)) - 3);
      1: begin
        case ($urandom_range(0, 3))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return DW'($urandom);
    endcase
  endfunction

  task automatic send_random_set(int n);
    int k;
    for (k = 0; k < n; k++) send_elem(rand_value(), k == n - 1);
  endtask

  task automatic test_single_element();
    send_elem(VAL_MAX, 1'b1);
    wait_drained();
  endtask

  task automatic test_extremes();
    send_elem(VAL_MIN, 1'b0);
    send_elem(VAL_MAX, 1'b0);
    send_elem('0, 1'b0);
    send_elem('1, 1'b0);
    send_elem(1, 1'b0);
    send_elem(VAL_MAX, 1'b0);
    send_elem(VAL_MIN, 1'b1);
    wait_drained();
  endtask

  task automatic test_equal_values();
    send_elem(5, 1'b0);
    send_elem(5, 1'b0);
    send_elem(-5, 1'b0);
    send_elem(5, 1'b1);
    wait_drained();
  endtask

  task automatic test_reverse_order();
    int k;
    for (k = 0; k < 8; k++) send_elem(100 - 30 * k, k == 7);
    wait_drained();
  endtask

  task automatic test_full_store();
    send_random_set(DEPTH);
    wait_drained();
  endtask

  // last-marked beat itself lands beyond the store
  task automatic test_overflow();
    send_random_set(DEPTH + 2);
    wait_drained();
  endtask

  task automatic test_backpressure();
    @(posedge clk);
    hold_len = 400;
    hold_req = 1'b1;
    send_random_set(30);
    send_random_set(6);
    wait_drained();
  endtask

  task automatic test_random_sets();
    int start;
    int n;
    start = items_sent;
    while (items_sent - start < RAND_ITEMS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 19))
        0:       n = DEPTH + $urandom_range(1, 6);
        1:       n = $urandom_range(13, DEPTH);
        default: n = $urandom_range(1, 12);
      endcase
      send_random_set(n);
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    in_ch.is_last = 1'b0;
    set_count     = 0;
    set_overflow  = 1'b0;
    error_count   = 0;
    items_sent    = 0;
    burst_left    = 0;
    gaps_on       = 1'b1;
    hold_req      = 1'b0;
    hold_len      = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_single_element();
    test_extremes();
    test_equal_values();
    test_reverse_order();
    test_full_store();
    test_overflow();
    test_backpressure();
    test_random_sets();

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    if (error_count == 0 && expected_beats.size() == 0)
      $display("shell_sort_gap_halving: match");
    else
      $display("shell_sort_gap_halving: mismatch");
    $finish;
  end

endmodule
